>>> rtl/core/dds_am_pkg.sv
// Shared types, constants and the sine table generator for the DDS AM modulator.
package dds_am_pkg;

   // Configuration register indexes
   localparam logic CSR_CARRIER_LEVEL   = 1'b0;
   localparam logic CSR_PHASE_INCREMENT = 1'b1;

   // Register reset values
   localparam logic [15:0] LEVEL_RESET     = 16'hFFFF;
   localparam logic [30:0] INCREMENT_RESET = 31'd847049155;

   // Voltage scale: 3200 LSB per volt
   localparam logic [14:0]        CARRIER_FULL = 15'd31968;
   localparam logic [14:0]        TEN_VOLTS    = 15'd32000;
   localparam logic signed [15:0] TEN_VOLTS_S  = 16'sd32000;

   // Reciprocals for floor(y / 125) after a shift by 8 (together a divide by 32000)
   localparam logic [15:0] WARN_RECIP = 16'd33555;
   localparam int          WARN_SHIFT = 22;
   localparam logic [22:0] CHAN_RECIP = 23'd4294968;
   localparam int          CHAN_SHIFT = 29;

   // Sine series constants, Q30
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   // Per-item control carried from front to back
   typedef struct packed {
      logic       neg;
      logic       conn_one;
      logic       conn_two;
      logic [14:0] gain_one;
      logic [14:0] gain_two;
      logic [7:0]  warn_one;
      logic [7:0]  warn_two;
   } front_item_type;

   // Quarter-wave sine, sin(pi/2 * k / 2^qshift), rounded to amplitude amp.
   // Evaluated at elaboration only, with constant arguments.
   function automatic logic [63:0] quarter_sine(input logic [63:0] k,
                                                input int unsigned qshift,
                                                input logic [63:0] amp);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        mag;
      logic signed [63:0] sum;
      x   = (PI_HALF_Q30 * k) >> qshift;
      x2  = (x * x) >> 30;
      sum = $signed(x);
      mag = ((x * x2) >> 30) / 64'd6;
      sum = sum - $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd20;
      sum = sum + $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd42;
      sum = sum - $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd72;
      sum = sum + $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd110;
      sum = sum - $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd156;
      sum = sum + $signed(mag);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      return ($unsigned(sum) * amp + (64'd1 << 29)) >> 30;
   endfunction

endpackage

>>> rtl/core/dds_am_front.sv
// Front end: phase accumulator, table index, CV clamping and warning levels.
module dds_am_front #(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [30:0]                    phase_increment,
   input  logic signed [15:0]             cv_one,
   input  logic signed [15:0]             cv_two,
   input  logic                           cv_one_connected,
   input  logic                           cv_two_connected,
   output dds_am_pkg::front_item_type     item,
   output logic [SINE_TABLE_BITS-2:0]     table_index
);

   localparam int TB = SINE_TABLE_BITS;
   localparam int QN = 1 << (TB - 2);

   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [TB-1:0]         idx;
   logic [TB-3:0]         rem_idx;

   // Clamp CV to 0..10 V
   function automatic logic [14:0] gain_of(input logic signed [15:0] cv);
      logic [14:0] g;
      if (cv < 16'sd0) begin
         g = 15'd0;
      end else if (cv > dds_am_pkg::TEN_VOLTS_S) begin
         g = dds_am_pkg::TEN_VOLTS;
      end else begin
         g = cv[14:0];
      end
      return g;
   endfunction

   // Negated CV clamped to 0..10 V, times 255 / 32000
   function automatic logic [7:0] warn_of(input logic signed [15:0] cv);
      logic [14:0] n;
      logic [22:0] nw;
      logic [30:0] p;
      if (cv >= 16'sd0) begin
         n = 15'd0;
      end else if (cv <= -dds_am_pkg::TEN_VOLTS_S) begin
         n = dds_am_pkg::TEN_VOLTS;
      end else begin
         n = 15'(-cv);
      end
      nw = (23'(n) << 8) - 23'(n);
      p  = 31'(nw[22:8]) * 31'(dds_am_pkg::WARN_RECIP);
      return p[dds_am_pkg::WARN_SHIFT+7:dds_am_pkg::WARN_SHIFT];
   endfunction

   // Advance the phase on every accepted item
   assign phase_in = phase_ff + PHASE_BITS'(phase_increment);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   // Fold the table index into one quadrant
   assign idx     = phase_in[PHASE_BITS-1 -: TB];
   assign rem_idx = idx[TB-3:0];

   always_comb begin
      if (idx[TB-2]) begin
         table_index = (TB-1)'(QN) - (TB-1)'(rem_idx);
      end else begin
         table_index = (TB-1)'(rem_idx);
      end
   end

   // Classify both channels
   always_comb begin
      item.neg      = idx[TB-1];
      item.conn_one = cv_one_connected;
      item.conn_two = cv_two_connected;
      item.gain_one = gain_of(cv_one);
      item.gain_two = gain_of(cv_two);
      item.warn_one = cv_one_connected ? warn_of(cv_one) : 8'd0;
      item.warn_two = cv_two_connected ? warn_of(cv_two) : 8'd0;
   end

endmodule

>>> rtl/core/dds_am_queue.sv
// Two-entry queue between the front end and the back end.
module dds_am_queue #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             not_empty
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full      = (count_ff == 2'(DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign rd_data   = mem_ff[rd_ptr_ff];

   // Track fill level
   always_comb begin
      unique case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (rd_en) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/core/dds_am_back.sv
// Back end: sine lookup, carrier scaling, per-channel modulation and result register.
module dds_am_back #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  dds_am_pkg::front_item_type  q_item,
   input  logic [SINE_TABLE_BITS-2:0]  q_index,
   output logic                        q_pop,
   input  logic [15:0]                 carrier_level,
   output logic                        empty,
   input  logic                        pop,
   output logic signed [15:0]          signal_one,
   output logic signed [15:0]          signal_two,
   output logic [7:0]                  warn_one,
   output logic [7:0]                  warn_two
);

   localparam int          TB  = SINE_TABLE_BITS;
   localparam int          MB  = SAMPLE_BITS - 1;
   localparam int          AMP = (1 << MB) - 1;
   localparam int          QN  = 1 << (TB - 2);
   localparam int          KC  = MB + 15;
   localparam logic [15:0] RC  = 16'(((64'd1) << KC) / 64'(AMP));
   localparam int          CS  = dds_am_pkg::CHAN_SHIFT;

   // Quarter-wave table, built at elaboration
   logic [MB-1:0] sine_rom [0:QN];

   for (genvar gk = 0; gk <= QN; gk++) begin : g_rom
      assign sine_rom[gk] = MB'(dds_am_pkg::quarter_sine(64'(gk), TB - 2, 64'(AMP)));
   end

   logic                       adv;
   logic [5:0]                 valid_ff;
   logic                       out_v_ff;
   dds_am_pkg::front_item_type item_ff [6];
   logic [16:0]                lvl;

   logic [MB-1:0]    mag1_ff;
   logic [MB-1:0]    mag1_in;
   logic [MB+14:0]   pa_ff;
   logic [MB+14:0]   pa_in;
   logic [MB+31:0]   pl;
   logic [KC-1:0]    a3_ff;
   logic [KC-1:0]    a3_in;
   logic [KC+15:0]   pq;
   logic [14:0]      q4_ff;
   logic [14:0]      q4_in;
   logic [KC-1:0]    a4_ff;
   logic [KC-1:0]    qd;
   logic [KC-1:0]    rem;
   logic [14:0]      cm5_ff;
   logic [14:0]      cm5_in;
   logic [29:0]      pc_one;
   logic [29:0]      pc_two;
   logic [21:0]      y_one_ff;
   logic [21:0]      y_two_ff;
   logic [14:0]      cm6_ff;
   logic [44:0]      pr_one;
   logic [44:0]      pr_two;
   logic [14:0]      mag_one;
   logic [14:0]      mag_two;
   logic signed [15:0] sig_one_in;
   logic signed [15:0] sig_two_in;

   // Move the whole pipeline unless a result is waiting and not taken
   assign adv   = !out_v_ff || pop;
   assign q_pop = q_valid && adv;
   assign empty = !out_v_ff;

   // Full level is treated as exactly one
   assign lvl = (carrier_level == dds_am_pkg::LEVEL_RESET) ? 17'h10000 : {1'b0, carrier_level};

   // Datapath between stages
   always_comb begin
      mag1_in = sine_rom[q_index];
      pa_in   = (MB+15)'(mag1_ff) * (MB+15)'(dds_am_pkg::CARRIER_FULL);
      pl      = (MB+32)'(pa_ff) * (MB+32)'(lvl);
      a3_in   = pl[MB+30:16];
      pq      = (KC+16)'(a3_ff) * (KC+16)'(RC);
      q4_in   = pq[KC+14:KC];
      qd      = (KC'(q4_ff) << MB) - KC'(q4_ff);
      rem     = a4_ff - qd;
      cm5_in  = (rem >= KC'(AMP)) ? (q4_ff + 15'd1) : q4_ff;
      pc_one  = 30'(cm5_ff) * 30'(item_ff[4].gain_one);
      pc_two  = 30'(cm5_ff) * 30'(item_ff[4].gain_two);
      pr_one  = 45'(y_one_ff) * 45'(dds_am_pkg::CHAN_RECIP);
      pr_two  = 45'(y_two_ff) * 45'(dds_am_pkg::CHAN_RECIP);
      mag_one = item_ff[5].conn_one ? pr_one[CS+14:CS] : cm6_ff;
      mag_two = item_ff[5].conn_two ? pr_two[CS+14:CS] : cm6_ff;
      sig_one_in = item_ff[5].neg ? -$signed(16'(mag_one)) : $signed(16'(mag_one));
      sig_two_in = item_ff[5].neg ? -$signed(16'(mag_two)) : $signed(16'(mag_two));
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= {valid_ff[4:0], q_valid};
         out_v_ff <= valid_ff[5];
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0] <= q_item;
         for (int i = 1; i < 6; i++) begin
            item_ff[i] <= item_ff[i-1];
         end
         mag1_ff    <= mag1_in;
         pa_ff      <= pa_in;
         a3_ff      <= a3_in;
         q4_ff      <= q4_in;
         a4_ff      <= a3_ff;
         cm5_ff     <= cm5_in;
         y_one_ff   <= pc_one[29:8];
         y_two_ff   <= pc_two[29:8];
         cm6_ff     <= cm5_ff;
         signal_one <= sig_one_in;
         signal_two <= sig_two_in;
         warn_one   <= item_ff[5].warn_one;
         warn_two   <= item_ff[5].warn_two;
      end
   end

   // Reciprocal estimate is off by at most one
   a_quot_close: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> ((KC+1)'(rem) < (KC+1)'(2 * AMP)))
      else $error("carrier quotient estimate off by more than one");

   // Carrier never exceeds 9.99 V
   a_carrier_max: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] |-> (cm5_ff <= dds_am_pkg::CARRIER_FULL))
      else $error("carrier magnitude out of range");

   // Results stay within the carrier swing
   a_signal_range: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> ((signal_one <= $signed({1'b0, dds_am_pkg::CARRIER_FULL}))
                 && (signal_one >= -$signed({1'b0, dds_am_pkg::CARRIER_FULL}))
                 && (signal_two <= $signed({1'b0, dds_am_pkg::CARRIER_FULL}))
                 && (signal_two >= -$signed({1'b0, dds_am_pkg::CARRIER_FULL}))))
      else $error("signal out of range");

   // A stalled pipeline keeps its items
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipeline moved while stalled");

endmodule

>>> rtl/core/dds_am_modulator_two_channel_unit.sv
// Top level of the two-channel DDS sine carrier with amplitude modulation.
//
// Each item pushed on the req_ side is one sample tick: it advances the
// phase accumulator and yields one result on the rsp_ side holding both
// modulated carriers and both negative-voltage warning levels.
// Input: an item is taken at a clock edge with push high and full low.
// Output: while empty is low the oldest result is on the rsp_ ports; it is
// taken at a clock edge with pop high.
// Throughput is one item per cycle while results are taken as they
// appear. Each item passes through the front end and its two-entry queue,
// then the registered sine lookup, multiplier stages and the result register.
// When pop stays low the back end pipeline holds, the queue fills and full
// rises after two more items; nothing is dropped.
// The csr_ port writes carrier_level (index 0) and phase_increment
// (index 1); write only while no item is in flight.
// Synchronous reset clears the phase to zero, empties the pipeline and
// queue, and sets carrier_level to full and phase_increment to its default.
module dds_am_modulator_two_channel_unit #(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [15:0] req_cv_one,
   input  logic signed [15:0] req_cv_two,
   input  logic               req_cv_one_connected,
   input  logic               req_cv_two_connected,
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_signal_one,
   output logic signed [15:0] rsp_signal_two,
   output logic [7:0]         rsp_warn_one,
   output logic [7:0]         rsp_warn_two,
   input  logic               csr_wen,
   input  logic               csr_index,
   input  logic [30:0]        csr_wdata
);

   localparam int QW = $bits(dds_am_pkg::front_item_type) + SINE_TABLE_BITS - 1;

   logic [15:0]                  level_ff;
   logic [30:0]                  increment_ff;
   logic                         accept;
   dds_am_pkg::front_item_type   f_item;
   logic [SINE_TABLE_BITS-2:0]   f_index;
   logic [QW-1:0]                q_rd_data;
   logic                         q_valid;
   logic                         q_pop;
   dds_am_pkg::front_item_type   q_item;
   logic [SINE_TABLE_BITS-2:0]   q_index;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= dds_am_pkg::LEVEL_RESET;
         increment_ff <= dds_am_pkg::INCREMENT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            dds_am_pkg::CSR_CARRIER_LEVEL:   level_ff     <= csr_wdata[15:0];
            dds_am_pkg::CSR_PHASE_INCREMENT: increment_ff <= csr_wdata;
            default:                         level_ff     <= level_ff;
         endcase
      end
   end

   assign accept = push && !full;

   dds_am_front #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .phase_increment  (increment_ff),
      .cv_one           (req_cv_one),
      .cv_two           (req_cv_two),
      .cv_one_connected (req_cv_one_connected),
      .cv_two_connected (req_cv_two_connected),
      .item             (f_item),
      .table_index      (f_index)
   );

   dds_am_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept),
      .wr_data   ({f_item, f_index}),
      .full      (full),
      .rd_en     (q_pop),
      .rd_data   (q_rd_data),
      .not_empty (q_valid)
   );

   // Split the queued entry
   assign {q_item, q_index} = q_rd_data;

   dds_am_back #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_index       (q_index),
      .q_pop         (q_pop),
      .carrier_level (level_ff),
      .empty         (empty),
      .pop           (pop),
      .signal_one    (rsp_signal_one),
      .signal_two    (rsp_signal_two),
      .warn_one      (rsp_warn_one),
      .warn_two      (rsp_warn_two)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-channel DDS sine AM modulator unit.
module tb;

   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 60;
   localparam int TAIL_CYCLES  = 16;
   localparam int REPORT_LIMIT = 10;

   // One sample tick offered on the request side
   typedef struct packed {
      logic signed [15:0] cv_one;
      logic signed [15:0] cv_two;
      logic               cv_one_connected;
      logic               cv_two_connected;
   } cv_sample_type;

   // One modulated output sample
   typedef struct packed {
      logic signed [15:0] signal_one;
      logic signed [15:0] signal_two;
      logic [7:0]         warn_one;
      logic [7:0]         warn_two;
   } am_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic signed [15:0] req_cv_one = '0;
   logic signed [15:0] req_cv_two = '0;
   logic               req_cv_one_connected = 1'b0;
   logic               req_cv_two_connected = 1'b0;
   logic               empty;
   logic               pop = 1'b0;
   logic signed [15:0] rsp_signal_one;
   logic signed [15:0] rsp_signal_two;
   logic [7:0]         rsp_warn_one;
   logic [7:0]         rsp_warn_two;
   logic               csr_wen = 1'b0;
   logic               csr_index = 1'b0;
   logic [30:0]        csr_wdata = '0;

   // Predictor state and register copies
   logic [31:0] phase_model = '0;
   logic [15:0] level_model = dds_am_pkg::LEVEL_RESET;
   logic [30:0] incr_model  = dds_am_pkg::INCREMENT_RESET;
   logic [15:0] quarter_amp [0:256];

   cv_sample_type sample_backlog [$];
   am_result_type predicted_outputs [$];
   cv_sample_type offered;
   am_result_type predicted;

   int  send_gap = 0;
   int  pop_gap = 0;
   int  stall_left = 0;
   int  idle_cycles = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  mismatches = 0;
   int  full_cycles = 0;
   int  long_holds = 0;
   int  settings_used = 1;
   bit  steady_tail = 1'b0;

   dds_am_modulator_two_channel_unit dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_cv_one           (req_cv_one),
      .req_cv_two           (req_cv_two),
      .req_cv_one_connected (req_cv_one_connected),
      .req_cv_two_connected (req_cv_two_connected),
      .empty                (empty),
      .pop                  (pop),
      .rsp_signal_one       (rsp_signal_one),
      .rsp_signal_two       (rsp_signal_two),
      .rsp_warn_one         (rsp_warn_one),
      .rsp_warn_two         (rsp_warn_two),
      .csr_wen              (csr_wen),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Quarter-wave point sin(pi/2 * k / 256) via odd series, scaled to 32767
   function automatic logic [15:0] sine_point(input int k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      acc;
      x    = (64'd1686629713 * 64'(k)) / 64'd256;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
         if (n % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 64'sd0;
      if (acc > 64'sd1073741824) acc = 64'sd1073741824;
      return 16'((64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30);
   endfunction

   // Scale carrier magnitude by the clamped CV; open jack passes the carrier
   function automatic logic signed [15:0] modulate(input logic [63:0] cmag, input logic neg,
                                                   input logic signed [15:0] cv,
                                                   input logic patched);
      logic [63:0] g;
      logic [63:0] m;
      logic [15:0] m16;
      if (!patched) begin
         m = cmag;
      end else begin
         if (cv < 0) g = 64'd0;
         else if (cv > 16'sd32000) g = 64'd32000;
         else g = {48'd0, cv};
         m = cmag * g / 64'd32000;
      end
      m16 = m[15:0];
      return neg ? -m16 : m16;
   endfunction

   // Negative CV clamped to ten volts, scaled to 0..255
   function automatic logic [7:0] warn_level(input logic signed [15:0] cv, input logic patched);
      int n;
      if (!patched) return 8'd0;
      n = -int'(cv);
      if (n < 0) n = 0;
      if (n > 32000) n = 32000;
      return 8'(n * 255 / 32000);
   endfunction

   // Advance the phase one tick and work out the output sample
   function automatic am_result_type modulate_tick(input cv_sample_type s);
      am_result_type r;
      logic [9:0]    idx;
      logic [63:0]   amp;
      logic [63:0]   lvl;
      logic [63:0]   cmag;
      phase_model = phase_model + {1'b0, incr_model};
      idx  = phase_model[31:22];
      amp  = 64'(idx[8] ? quarter_amp[256 - int'(idx[7:0])] : quarter_amp[idx[7:0]]);
      lvl  = (level_model == 16'hFFFF) ? 64'd65536 : {48'd0, level_model};
      cmag = amp * 64'd31968 * lvl / (64'd32767 * 64'd65536);
      r.signal_one = modulate(cmag, idx[9], s.cv_one, s.cv_one_connected);
      r.signal_two = modulate(cmag, idx[9], s.cv_two, s.cv_two_connected);
      r.warn_one   = warn_level(s.cv_one, s.cv_one_connected);
      r.warn_two   = warn_level(s.cv_two, s.cv_two_connected);
      return r;
   endfunction

   function automatic logic signed [15:0] random_cv();
      int v;
      case ($urandom_range(0, 5))
         0: v = int'($urandom_range(0, 65535)) - 32768;
         1: v = int'($urandom_range(0, 32000));
         2: v = -int'($urandom_range(0, 32000));
         3: v = 32000 + int'($urandom_range(0, 767));
         4: v = -32768 + int'($urandom_range(0, 768));
         default: begin
            case ($urandom_range(0, 8))
               0: v = 0;
               1: v = -1;
               2: v = 1;
               3: v = 32000;
               4: v = 32001;
               5: v = -32000;
               6: v = -32001;
               7: v = 32767;
               default: v = -32768;
            endcase
         end
      endcase
      return 16'(v);
   endfunction

   task automatic add_sample(input int cv1, input int cv2, input bit c1, input bit c2);
      cv_sample_type s;
      s.cv_one = 16'(cv1);
      s.cv_two = 16'(cv2);
      s.cv_one_connected = c1;
      s.cv_two_connected = c2;
      sample_backlog.push_back(s);
   endtask

   // Hold until every queued item has been taken and every result returned
   task automatic wait_drained();
      @(negedge clock);
      while (sample_backlog.size() != 0 || push || predicted_outputs.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [30:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         dds_am_pkg::CSR_CARRIER_LEVEL:   level_model = value[15:0];
         dds_am_pkg::CSR_PHASE_INCREMENT: incr_model  = value;
      endcase
   endtask

   task automatic run_setting(input logic [15:0] level, input logic [30:0] incr, input int count);
      write_csr(dds_am_pkg::CSR_CARRIER_LEVEL, {15'd0, level});
      write_csr(dds_am_pkg::CSR_PHASE_INCREMENT, incr);
      settings_used++;
      @(negedge clock);
      for (int i = 0; i < count; i++)
         add_sample(int'(random_cv()), int'(random_cv()), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 3) != 0);
      wait_drained();
   endtask

   // Stimulus: directed samples at reset settings, then random samples under several register settings
   initial begin
      for (int k = 0; k <= 256; k++) quarter_amp[k] = sine_point(k);
      @(negedge clock);
      while (reset) @(negedge clock);

      add_sample(0, 0, 1, 1);
      add_sample(32000, 32000, 1, 1);
      add_sample(32767, -32768, 1, 1);
      add_sample(32001, -32001, 1, 1);
      add_sample(-1, 1, 1, 1);
      add_sample(-32000, 16000, 1, 1);
      add_sample(16000, -16000, 1, 1);
      add_sample(100, -100, 0, 0);
      add_sample(-32768, 32767, 0, 1);
      add_sample(32767, -32768, 1, 0);
      add_sample(12345, -12345, 0, 0);
      add_sample(-20000, 25000, 1, 1);
      add_sample(0, -1, 1, 1);
      add_sample(31999, -31999, 1, 1);
      add_sample(-128, 255, 1, 1);
      add_sample(21845, -21846, 1, 1);
      add_sample(-32768, -32768, 1, 1);
      add_sample(32767, 32767, 1, 1);
      add_sample(-5000, 5000, 1, 0);
      add_sample(8000, 24000, 1, 1);
      wait_drained();

      run_setting(16'd0, 31'h7FFF_FFFF, 60);
      run_setting(16'd1, 31'd0, 60);
      run_setting(16'd65534, 31'd12582913, 300);
      run_setting(16'hFFFF, 31'($urandom), 300);
      run_setting(16'($urandom), 31'($urandom), 250);
      steady_tail = 1'b1;
      run_setting(16'd40000, 31'($urandom_range(0, 1 << 26)), 200);

      repeat (TAIL_CYCLES) @(posedge clock);
      mismatches += predicted_outputs.size();
      $display("Covered %0d sample ticks over %0d register settings; %0d results checked.",
               items_sent, settings_used, results_seen);
      $display("Input back-pressure on %0d cycles, %0d long output holds, %0d mismatches.",
               full_cycles, long_holds, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Driver: offer backlog items, predict each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            predicted = modulate_tick(offered);
            predicted_outputs.push_back(predicted);
            items_sent++;
         end
         if (push && full) full_cycles++;
         if (!push || !full) begin
            if (send_gap > 0) begin
               send_gap--;
               push <= 1'b0;
            end else if (sample_backlog.size() > 0) begin
               offered = sample_backlog.pop_front();
               req_cv_one           <= offered.cv_one;
               req_cv_two           <= offered.cv_two;
               req_cv_one_connected <= offered.cv_one_connected;
               req_cv_two_connected <= offered.cv_two_connected;
               push <= 1'b1;
               if (!steady_tail && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 6);
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Compare the taken result with the oldest prediction
   task automatic check_result();
      am_result_type want;
      if (predicted_outputs.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("ERROR: result %0d/%0d/%0d/%0d with nothing predicted",
                     rsp_signal_one, rsp_signal_two, rsp_warn_one, rsp_warn_two);
      end else begin
         want = predicted_outputs.pop_front();
         if (rsp_signal_one !== want.signal_one || rsp_signal_two !== want.signal_two ||
             rsp_warn_one !== want.warn_one || rsp_warn_two !== want.warn_two) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: result %0d: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                        results_seen, want.signal_one, want.signal_two, want.warn_one,
                        want.warn_two, rsp_signal_one, rsp_signal_two, rsp_warn_one,
                        rsp_warn_two);
         end
      end
      results_seen++;
   endtask

   // Monitor: take results, with random gaps and two long holds
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            check_result();
            if (results_seen == 300 || results_seen == 600) begin
               stall_left = LONG_HOLD;
               long_holds++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
         end else if (!steady_tail && $urandom_range(0, 9) == 0) begin
            pop_gap = $urandom_range(0, 5);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> dds_am_modulator_two_channel_unit.f
rtl/core/dds_am_pkg.sv
rtl/core/dds_am_front.sv
rtl/core/dds_am_queue.sv
rtl/core/dds_am_back.sv
rtl/core/dds_am_modulator_two_channel_unit.sv
tb/tb.sv
